[hw/rtl/asc_pkg.sv]
// Shared types, constants and helpers of the analog sample conditioner.
`timescale 1ns / 1ps

package asc_pkg;

  localparam int DATA_W    = 32;
  localparam int ACC_W     = 64;
  localparam int LIMIT_W   = 12;
  localparam int WEIGHT_W  = 17;
  localparam int MODE_W    = 3;
  localparam int LINK_W    = 2;
  localparam int CFG_IDX_W = 3;

  // Mode register bits
  localparam int MODE_EMA   = 0;
  localparam int MODE_CLAMP = 1;
  localparam int MODE_SCALE = 2;

  // Fixed-point constants (Q16.16 / Q1.16)
  localparam int FRAC_BITS = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);
  localparam logic signed [DATA_W-1:0] LEVEL_THRESH = 32'sd32768;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 64'sd32768;
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // Quality codes
  localparam logic [1:0] QUAL_GOOD  = 2'd0;
  localparam logic [1:0] QUAL_STALE = 2'd1;
  localparam logic [1:0] QUAL_FAULT = 2'd2;
  localparam logic [1:0] QUAL_RANGE = 2'd3;

  // Status codes
  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_RANGE       = 2'd1;
  localparam logic [1:0] STAT_CLAMP       = 2'd2;
  localparam logic [1:0] STAT_RANGE_CLAMP = 2'd3;

  // Result tdata layout
  localparam int OUT_VALUE_LSB  = 0;
  localparam int OUT_LEVEL_BIT  = 32;
  localparam int OUT_QUAL_LSB   = 33;
  localparam int OUT_STATUS_LSB = 35;
  localparam int OUT_TDATA_W    = 40;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_LIMIT_A = 3'd0,
    REG_RAW_LIMIT_B = 3'd1,
    REG_GAIN        = 3'd2,
    REG_BIAS        = 3'd3,
    REG_WEIGHT      = 3'd4,
    REG_CLAMP_LOW   = 3'd5,
    REG_CLAMP_HIGH  = 3'd6,
    REG_MODE        = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0]       raw_limit_a;
    logic [LIMIT_W-1:0]       raw_limit_b;
    logic signed [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] bias;
    logic [WEIGHT_W-1:0]      smoothing_weight;
    logic signed [DATA_W-1:0] clamp_low;
    logic signed [DATA_W-1:0] clamp_high;
    logic [MODE_W-1:0]        mode_flags;
  } cfg_t;

  // Saturate a 64-bit signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){v[ACC_W-1]}}) begin
      r = v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = SAT_MIN;
    end else begin
      r = SAT_MAX;
    end
    return r;
  endfunction

endpackage

[hw/rtl/asc_cfg_regs.sv]
// Configuration register bank of the analog sample conditioner.
`timescale 1ns / 1ps

module asc_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]    cfg_addr_i,
  input  logic [asc_pkg::DATA_W-1:0]       cfg_wdata_i,
  output asc_pkg::cfg_t                    cfg_o
);

  asc_pkg::cfg_t cfg_q;

  // Write one register per enabled cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_limit_a      <= asc_pkg::LIMIT_W'(0);
      cfg_q.raw_limit_b      <= asc_pkg::LIMIT_W'(4095);
      cfg_q.gain             <= 32'sd1600;
      cfg_q.bias             <= 32'sd0;
      cfg_q.smoothing_weight <= asc_pkg::WEIGHT_W'(13107);
      cfg_q.clamp_low        <= 32'sd0;
      cfg_q.clamp_high       <= 32'sd6553600;
      cfg_q.mode_flags       <= asc_pkg::MODE_W'(0);
    end else if (cfg_we_i) begin
      unique case (asc_pkg::reg_idx_e'(cfg_addr_i))
        asc_pkg::REG_RAW_LIMIT_A: cfg_q.raw_limit_a <= cfg_wdata_i[asc_pkg::LIMIT_W-1:0];
        asc_pkg::REG_RAW_LIMIT_B: cfg_q.raw_limit_b <= cfg_wdata_i[asc_pkg::LIMIT_W-1:0];
        asc_pkg::REG_GAIN:        cfg_q.gain        <= cfg_wdata_i;
        asc_pkg::REG_BIAS:        cfg_q.bias        <= cfg_wdata_i;
        asc_pkg::REG_WEIGHT:
          cfg_q.smoothing_weight <= cfg_wdata_i[asc_pkg::WEIGHT_W-1:0];
        asc_pkg::REG_CLAMP_LOW:   cfg_q.clamp_low   <= cfg_wdata_i;
        asc_pkg::REG_CLAMP_HIGH:  cfg_q.clamp_high  <= cfg_wdata_i;
        asc_pkg::REG_MODE:        cfg_q.mode_flags  <= cfg_wdata_i[asc_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/asc_mac.sv]
// Shared multiply-add unit with a registered result.
`timescale 1ns / 1ps

module asc_mac #(
  parameter int B_W = 18
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [asc_pkg::DATA_W:0]   a_i,
  input  logic signed [B_W-1:0]             b_i,
  input  logic signed [asc_pkg::ACC_W-1:0]  c_i,
  output logic signed [asc_pkg::ACC_W-1:0]  p_o
);

  localparam int P_W = asc_pkg::DATA_W + 1 + B_W;

  logic signed [P_W-1:0]            prod;
  logic signed [asc_pkg::ACC_W-1:0] p_d;
  logic signed [asc_pkg::ACC_W-1:0] p_q;

  // Multiply, sign-extend and add
  assign prod = a_i * b_i;
  assign p_d  = $signed({{(asc_pkg::ACC_W-P_W){prod[P_W-1]}}, prod}) + c_i;

  // Hold the result for the sequencer
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[hw/rtl/analog_sample_conditioner_top.sv]
// Top level of the analog sample conditioner: sequencer, filter state and output register.
`timescale 1ns / 1ps

// One raw sample enters per item and yields one result item: value in signed
// Q16.16, level bit, quality and status. Each item goes through the steps accept,
// scale, filter and finish; with smoothing enabled and the filter seeded it also
// goes through a smoothing step and a state update, because the single multiply-add
// unit is used a second time for the smoothing step. The block is not ready while
// an item is in work; the finished result sits in an output register, so the next
// item can be taken while the result still waits on m_axis_tready. Configuration must be
// written only while no item is in work; the block itself does not enforce this.
module analog_sample_conditioner_top #(
  parameter int RAW_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream, tdata: raw_sample [RAW_BITS-1:0], link_quality [RAW_BITS+1:RAW_BITS]
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [((RAW_BITS+9)/8)*8-1:0]      s_axis_tdata,
  // Result stream, tdata: eng_value [31:0], level_bit [32], sample_quality [34:33],
  // status_code [36:35], zero [39:37]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [asc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [asc_pkg::CFG_IDX_W-1:0]      cfg_addr_i,
  input  logic [asc_pkg::DATA_W-1:0]         cfg_wdata_i
);

  localparam int B_W   = (RAW_BITS + 1 > 18) ? RAW_BITS + 1 : 18;
  localparam int CMP_W = (RAW_BITS > asc_pkg::LIMIT_W) ? RAW_BITS : asc_pkg::LIMIT_W;
  localparam int DW    = asc_pkg::DATA_W;
  localparam int AW    = asc_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCALE,
    S_FILT,
    S_EMA,
    S_UPD,
    S_DONE
  } state_e;

  asc_pkg::cfg_t cfg;

  state_e                     state_q;
  logic [RAW_BITS-1:0]        raw_q;
  logic [asc_pkg::LINK_W-1:0] link_q;
  logic signed [DW-1:0]       v_q;
  logic signed [DW-1:0]       s_q;
  logic                       seeded_q;
  logic                       out_valid_q;
  logic signed [DW-1:0]       out_value_q;
  logic                       out_level_q;
  logic [1:0]                 out_qual_q;
  logic [1:0]                 out_status_q;

  logic                       mac_en;
  logic signed [DW:0]         mac_a;
  logic signed [B_W-1:0]      mac_b;
  logic signed [AW-1:0]       mac_c;
  logic signed [AW-1:0]       mac_p;

  logic [asc_pkg::WEIGHT_W-1:0] w_clip;
  logic signed [DW:0]           diff;
  logic [AW-1:0]                pass_wide;
  logic signed [DW-1:0]         pass_val;
  logic signed [DW-1:0]         scaled_val;
  logic signed [AW-1:0]         ema_step;
  logic signed [DW-1:0]         ema_val;

  logic                         in_accept;
  logic                         out_load;
  logic [CMP_W-1:0]             raw_cmp;
  logic [CMP_W-1:0]             lim_a;
  logic [CMP_W-1:0]             lim_b;
  logic [CMP_W-1:0]             lim_lo;
  logic [CMP_W-1:0]             lim_hi;
  logic                         raw_outside;
  logic signed [DW-1:0]         v_in;
  logic signed [DW-1:0]         v_lo;
  logic signed [DW-1:0]         v_fin;
  logic                         clamped;
  logic [1:0]                   qual_base;
  logic [1:0]                   qual_fin;
  logic [1:0]                   status_fin;

  asc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  asc_mac #(
    .B_W (B_W)
  ) u_mac (
    .clk_i (clk_i),
    .en_i  (mac_en),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .p_o   (mac_p)
  );

  // Handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

  // Feed the shared unit: raw*gain+bias when scaling, w*diff+half when smoothing
  assign w_clip = cfg.smoothing_weight[asc_pkg::WEIGHT_W-1] ?
                  asc_pkg::WEIGHT_ONE : cfg.smoothing_weight;
  assign diff   = $signed({v_q[DW-1], v_q}) - $signed({s_q[DW-1], s_q});
  assign mac_en = (state_q == S_SCALE) || (state_q == S_EMA);

  always_comb begin
    if (state_q == S_SCALE) begin
      mac_a = $signed({cfg.gain[DW-1], cfg.gain});
      mac_b = $signed({{(B_W-RAW_BITS){1'b0}}, raw_q});
      mac_c = $signed({{(AW-DW){cfg.bias[DW-1]}}, cfg.bias});
    end else begin
      mac_a = diff;
      mac_b = $signed({{(B_W-asc_pkg::WEIGHT_W){1'b0}}, w_clip});
      mac_c = asc_pkg::ROUND_HALF;
    end
  end

  // Passthrough value and scaled value
  assign pass_wide  = {{(AW-RAW_BITS){1'b0}}, raw_q} << asc_pkg::FRAC_BITS;
  assign pass_val   = asc_pkg::sat32($signed(pass_wide));
  assign scaled_val = asc_pkg::sat32(mac_p);

  // Smoothing update: floor shift of the rounded weighted step
  assign ema_step = mac_p >>> asc_pkg::FRAC_BITS;
  assign ema_val  = asc_pkg::sat32($signed({{(AW-DW){s_q[DW-1]}}, s_q}) + ema_step);

  // Range check against the raw limits in either order
  assign raw_cmp     = CMP_W'(raw_q);
  assign lim_a       = CMP_W'(cfg.raw_limit_a);
  assign lim_b       = CMP_W'(cfg.raw_limit_b);
  assign lim_lo      = (lim_a < lim_b) ? lim_a : lim_b;
  assign lim_hi      = (lim_a < lim_b) ? lim_b : lim_a;
  assign raw_outside = (raw_cmp < lim_lo) || (raw_cmp > lim_hi);

  // Finish: select value, clamp, derive quality and status
  always_comb begin
    qual_base  = (link_q == asc_pkg::QUAL_RANGE) ? asc_pkg::QUAL_FAULT : link_q;
    qual_fin   = qual_base;
    status_fin = asc_pkg::STAT_OK;
    v_in       = (cfg.mode_flags[asc_pkg::MODE_SCALE] && cfg.mode_flags[asc_pkg::MODE_EMA]) ?
                 s_q : v_q;
    v_lo       = (v_in < cfg.clamp_low) ? cfg.clamp_low : v_in;
    v_fin      = v_in;
    clamped    = 1'b0;
    if (cfg.mode_flags[asc_pkg::MODE_SCALE]) begin
      if (raw_outside) begin
        status_fin = asc_pkg::STAT_RANGE;
        if (qual_base == asc_pkg::QUAL_GOOD) begin
          qual_fin = asc_pkg::QUAL_RANGE;
        end
      end
      if (cfg.mode_flags[asc_pkg::MODE_CLAMP]) begin
        clamped = (v_in < cfg.clamp_low) || (v_lo > cfg.clamp_high);
        v_fin   = (v_lo > cfg.clamp_high) ? cfg.clamp_high : v_lo;
        if (clamped) begin
          status_fin = (qual_fin == asc_pkg::QUAL_RANGE) ?
                       asc_pkg::STAT_RANGE_CLAMP : asc_pkg::STAT_CLAMP;
        end
      end
    end
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      raw_q        <= '0;
      link_q       <= '0;
      v_q          <= '0;
      s_q          <= '0;
      seeded_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_level_q  <= 1'b0;
      out_qual_q   <= '0;
      out_status_q <= '0;
    end else begin
      // Raise valid on load, drop it once the result is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            raw_q   <= s_axis_tdata[RAW_BITS-1:0];
            link_q  <= s_axis_tdata[RAW_BITS +: asc_pkg::LINK_W];
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_q <= S_FILT;
        end
        S_FILT: begin
          if (!cfg.mode_flags[asc_pkg::MODE_SCALE]) begin
            v_q     <= pass_val;
            state_q <= S_DONE;
          end else begin
            v_q <= scaled_val;
            if (cfg.mode_flags[asc_pkg::MODE_EMA] && seeded_q) begin
              state_q <= S_EMA;
            end else begin
              if (cfg.mode_flags[asc_pkg::MODE_EMA]) begin
                s_q      <= scaled_val;
                seeded_q <= 1'b1;
              end
              state_q <= S_DONE;
            end
          end
        end
        S_EMA: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          s_q     <= ema_val;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_value_q  <= v_fin;
            out_level_q  <= (v_fin > asc_pkg::LEVEL_THRESH);
            out_qual_q   <= qual_fin;
            out_status_q <= status_fin;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_status_q, out_qual_q, out_level_q, out_value_q};

endmodule

[hw/rtl/asc_checker.sv]
// Port-level checker of the analog sample conditioner and its bind.
`timescale 1ns / 1ps

module asc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [asc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again right after an accept");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Level bit follows the value against one half
  a_level_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[asc_pkg::OUT_LEVEL_BIT] ==
      ($signed(m_axis_tdata[asc_pkg::OUT_VALUE_LSB +: asc_pkg::DATA_W]) >
       asc_pkg::LEVEL_THRESH))
    else $error("level bit disagrees with value");

  // Range-and-clamp status only comes with out-of-range quality
  a_status_quality: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid &&
    m_axis_tdata[asc_pkg::OUT_STATUS_LSB +: 2] == asc_pkg::STAT_RANGE_CLAMP |->
      m_axis_tdata[asc_pkg::OUT_QUAL_LSB +: 2] == asc_pkg::QUAL_RANGE)
    else $error("status and quality disagree");

endmodule

bind analog_sample_conditioner_top asc_checker u_asc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/testbench.sv]
// Self-checking testbench for the analog sample conditioner top level.
`timescale 1ns / 1ps

module testbench;

  localparam int IDLE_LIMIT = 3000;
  localparam int PHASES     = 29;
  localparam int PHASE_LEN  = 50;
  localparam int CALM_FROM  = 26;

  localparam logic [31:0] M_EMA   = 32'd1 << asc_pkg::MODE_EMA;
  localparam logic [31:0] M_CLAMP = 32'd1 << asc_pkg::MODE_CLAMP;
  localparam logic [31:0] M_SCALE = 32'd1 << asc_pkg::MODE_SCALE;

  localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] value;
    logic               level;
    logic [1:0]         quality;
    logic [1:0]         status;
  } cond_result_t;

  typedef enum logic [1:0] {ROW_WRITE, ROW_SAMPLE, ROW_KNOWN} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    asc_pkg::reg_idx_e  idx;
    logic [31:0]        wdata;
    logic [11:0]        raw;
    logic [1:0]         link;
    cond_result_t       want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // tdata: raw_sample [11:0], link_quality [13:12], zero [15:14]
  logic [15:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // tdata: eng_value [31:0], level_bit [32], sample_quality [34:33],
  // status_code [36:35], zero [39:37]
  logic [asc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  // Shadow of the register file, reset values
  logic [11:0]        lim_a      = 12'd0;
  logic [11:0]        lim_b      = 12'd4095;
  logic signed [31:0] gain_r     = 32'sd1600;
  logic signed [31:0] bias_r     = 32'sd0;
  logic [16:0]        weight_r   = 17'd13107;
  logic signed [31:0] clamp_lo_r = 32'sd0;
  logic signed [31:0] clamp_hi_r = 32'sd6553600;
  logic [2:0]         mode_r     = 3'd0;

  // Filter state of the predictor
  logic signed [31:0] smooth_r = 32'sd0;
  logic               filter_seeded = 1'b0;

  cond_result_t pending_results[$];
  cond_result_t oldest;
  int mismatch_cnt = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  bit calm = 1'b0;

  always #1 clk_i = ~clk_i;

  analog_sample_conditioner_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
    if (x > WIDE_MAX) return WIDE_MAX[31:0];
    if (x < WIDE_MIN) return WIDE_MIN[31:0];
    return x[31:0];
  endfunction

  // Work out the result of one sample and advance the filter state
  function automatic cond_result_t condition_sample(input logic [11:0] raw,
                                                    input logic [1:0] link);
    cond_result_t r;
    logic signed [31:0] v;
    logic signed [63:0] wide, w_eff, diff, step;
    logic [11:0] lo, hi;
    logic clipped;
    r.quality = (link == 2'd3) ? asc_pkg::QUAL_FAULT : link;
    r.status = asc_pkg::STAT_OK;
    if (mode_r[asc_pkg::MODE_SCALE]) begin
      wide = $signed({52'd0, raw}) * gain_r + bias_r;
      v = clip32(wide);
      if (mode_r[asc_pkg::MODE_EMA]) begin
        if (!filter_seeded) begin
          smooth_r = v;
          filter_seeded = 1'b1;
        end else begin
          w_eff = (weight_r > 17'd65536) ? 64'sd65536 : $signed({47'd0, weight_r});
          diff = v;
          diff = diff - smooth_r;
          // round to nearest, ties toward plus infinity
          step = (w_eff * diff + 64'sd32768) >>> 16;
          wide = smooth_r;
          smooth_r = clip32(wide + step);
        end
        v = smooth_r;
      end
      // limits may come in either order
      lo = (lim_a < lim_b) ? lim_a : lim_b;
      hi = (lim_a < lim_b) ? lim_b : lim_a;
      if (raw < lo || raw > hi) begin
        if (r.quality == asc_pkg::QUAL_GOOD) r.quality = asc_pkg::QUAL_RANGE;
        r.status = asc_pkg::STAT_RANGE;
      end
      if (mode_r[asc_pkg::MODE_CLAMP]) begin
        clipped = 1'b0;
        if (v < clamp_lo_r) begin
          v = clamp_lo_r;
          clipped = 1'b1;
        end
        if (v > clamp_hi_r) begin
          v = clamp_hi_r;
          clipped = 1'b1;
        end
        if (clipped) begin
          r.status = (r.quality == asc_pkg::QUAL_RANGE) ?
                     asc_pkg::STAT_RANGE_CLAMP : asc_pkg::STAT_CLAMP;
        end
      end
    end else begin
      v = {4'd0, raw, 16'd0};
    end
    r.value = v;
    r.level = (v > 32'sd32768);
    return r;
  endfunction

  function automatic plan_row_t cfg_step(input asc_pkg::reg_idx_e idx,
                                         input logic [31:0] val);
    plan_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.wdata = val;
    return r;
  endfunction

  function automatic plan_row_t sample_step(input logic [11:0] raw, input logic [1:0] link);
    plan_row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.raw = raw;
    r.link = link;
    return r;
  endfunction

  function automatic plan_row_t known_step(input logic [11:0] raw, input logic [1:0] link,
                                           input logic [31:0] value, input logic level,
                                           input logic [1:0] quality, input logic [1:0] status);
    plan_row_t r;
    r = sample_step(raw, link);
    r.kind = ROW_KNOWN;
    r.want = {value, level, quality, status};
    return r;
  endfunction

  // Random signed word: extremes, zero, full range or a moderate magnitude
  function automatic logic [31:0] pick_word(input int span);
    logic [31:0] w;
    case ($urandom_range(0, 7))
      0: w = 32'h7FFF_FFFF;
      1: w = 32'h8000_0000;
      2: w = $urandom;
      3: w = 32'd0;
      default: begin
        w = $urandom_range(0, (32'd1 << span) - 1);
        if ($urandom_range(0, 1)) w = -w;
      end
    endcase
    return w;
  endfunction

  task automatic write_reg(input asc_pkg::reg_idx_e idx, input logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      asc_pkg::REG_RAW_LIMIT_A: lim_a = val[11:0];
      asc_pkg::REG_RAW_LIMIT_B: lim_b = val[11:0];
      asc_pkg::REG_GAIN:        gain_r = val;
      asc_pkg::REG_BIAS:        bias_r = val;
      asc_pkg::REG_WEIGHT:      weight_r = val[16:0];
      asc_pkg::REG_CLAMP_LOW:   clamp_lo_r = val;
      asc_pkg::REG_CLAMP_HIGH:  clamp_hi_r = val;
      asc_pkg::REG_MODE:        mode_r = val[2:0];
      default: ;
    endcase
  endtask

  // Hold input, wait for every outstanding result, then let the pipeline empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offer one item, predict on accept, then maybe drop valid for a burst
  task automatic send_item(input logic [11:0] raw, input logic [1:0] link,
                           input bit known, input cond_result_t want);
    cond_result_t guess;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, link, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    guess = condition_sample(raw, link);
    pending_results.push_back(known ? want : guess);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic randomize_setup();
    logic [31:0] lo_c, hi_c, mode_c;
    case ($urandom_range(0, 3))
      0: begin
        write_reg(asc_pkg::REG_RAW_LIMIT_A, 32'd0);
        write_reg(asc_pkg::REG_RAW_LIMIT_B, 32'd4095);
      end
      1: begin
        write_reg(asc_pkg::REG_RAW_LIMIT_A, 32'd4095);
        write_reg(asc_pkg::REG_RAW_LIMIT_B, 32'd0);
      end
      default: begin
        write_reg(asc_pkg::REG_RAW_LIMIT_A, $urandom_range(0, 4095));
        write_reg(asc_pkg::REG_RAW_LIMIT_B, $urandom_range(0, 4095));
      end
    endcase
    write_reg(asc_pkg::REG_GAIN, pick_word(17));
    write_reg(asc_pkg::REG_BIAS, pick_word(27));
    case ($urandom_range(0, 5))
      0: write_reg(asc_pkg::REG_WEIGHT, 32'd0);
      1: write_reg(asc_pkg::REG_WEIGHT, 32'd65536);
      2: write_reg(asc_pkg::REG_WEIGHT, $urandom_range(65537, 131071));
      default: write_reg(asc_pkg::REG_WEIGHT, $urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 7))
      0: begin
        lo_c = 32'h8000_0000;
        hi_c = 32'h7FFF_FFFF;
      end
      1: begin
        // crossed bounds
        lo_c = $urandom_range(32'd1 << 20, 32'd1 << 26);
        hi_c = lo_c - $urandom_range(1, 32'd1 << 20);
      end
      default: begin
        lo_c = $urandom_range(0, 32'd1 << 26);
        if ($urandom_range(0, 1)) lo_c = -lo_c;
        hi_c = lo_c + $urandom_range(0, 32'd1 << 27);
      end
    endcase
    write_reg(asc_pkg::REG_CLAMP_LOW, lo_c);
    write_reg(asc_pkg::REG_CLAMP_HIGH, hi_c);
    mode_c = $urandom_range(0, 7);
    if ($urandom_range(0, 2) != 0) mode_c = mode_c | M_SCALE;
    write_reg(asc_pkg::REG_MODE, mode_c);
  endtask

  task automatic note_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    end
  endtask

  // Receiver: stall in random bursts, at a rate set per phase
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with nothing expected, actual %h", $time, m_axis_tdata);
      end else begin
        oldest = pending_results.pop_front();
        note_field("eng_value", oldest.value,
                   m_axis_tdata[asc_pkg::OUT_VALUE_LSB +: 32]);
        note_field("level_bit", oldest.level, m_axis_tdata[asc_pkg::OUT_LEVEL_BIT]);
        note_field("sample_quality", oldest.quality,
                   m_axis_tdata[asc_pkg::OUT_QUAL_LSB +: 2]);
        note_field("status_code", oldest.status,
                   m_axis_tdata[asc_pkg::OUT_STATUS_LSB +: 2]);
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken result
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t plan[$];
    logic [11:0] raw, lo_lim, hi_lim;
    logic [1:0] link;
    int r;

    plan = '{
      // passthrough after reset, link value 3 reads as fault
      known_step(12'd0, 2'd0, 32'h0000_0000, 1'b0, asc_pkg::QUAL_GOOD, asc_pkg::STAT_OK),
      known_step(12'd4095, 2'd3, 32'h0FFF_0000, 1'b1, asc_pkg::QUAL_FAULT, asc_pkg::STAT_OK),
      sample_step(12'hAAA, 2'd1),
      sample_step(12'h555, 2'd2),
      // scaling with reset gain, then the level threshold itself
      cfg_step(asc_pkg::REG_MODE, M_SCALE),
      sample_step(12'd4095, 2'd0),
      cfg_step(asc_pkg::REG_GAIN, 32'h0000_8000),
      known_step(12'd1, 2'd0, 32'h0000_8000, 1'b0, asc_pkg::QUAL_GOOD, asc_pkg::STAT_OK),
      sample_step(12'd2, 2'd0),
      // saturation at both ends
      cfg_step(asc_pkg::REG_GAIN, 32'h7FFF_FFFF),
      cfg_step(asc_pkg::REG_BIAS, 32'h7FFF_FFFF),
      known_step(12'd4095, 2'd0, 32'h7FFF_FFFF, 1'b1, asc_pkg::QUAL_GOOD, asc_pkg::STAT_OK),
      cfg_step(asc_pkg::REG_GAIN, 32'h8000_0000),
      cfg_step(asc_pkg::REG_BIAS, 32'h8000_0000),
      known_step(12'd4095, 2'd1, 32'h8000_0000, 1'b0, asc_pkg::QUAL_STALE, asc_pkg::STAT_OK),
      // range check with limits given high end first
      cfg_step(asc_pkg::REG_GAIN, 32'd0),
      cfg_step(asc_pkg::REG_BIAS, 32'd0),
      cfg_step(asc_pkg::REG_RAW_LIMIT_A, 32'd200),
      cfg_step(asc_pkg::REG_RAW_LIMIT_B, 32'd100),
      known_step(12'd99, 2'd0, 32'h0000_0000, 1'b0, asc_pkg::QUAL_RANGE, asc_pkg::STAT_RANGE),
      known_step(12'd201, 2'd1, 32'h0000_0000, 1'b0, asc_pkg::QUAL_STALE, asc_pkg::STAT_RANGE),
      known_step(12'd150, 2'd2, 32'h0000_0000, 1'b0, asc_pkg::QUAL_FAULT, asc_pkg::STAT_OK),
      known_step(12'd100, 2'd3, 32'h0000_0000, 1'b0, asc_pkg::QUAL_FAULT, asc_pkg::STAT_OK),
      // clamp below, combined with range, and with a stale link
      cfg_step(asc_pkg::REG_MODE, M_SCALE | M_CLAMP),
      cfg_step(asc_pkg::REG_BIAS, 32'hFFFF_0000),
      known_step(12'd150, 2'd0, 32'h0000_0000, 1'b0, asc_pkg::QUAL_GOOD, asc_pkg::STAT_CLAMP),
      known_step(12'd50, 2'd0, 32'h0000_0000, 1'b0, asc_pkg::QUAL_RANGE,
                 asc_pkg::STAT_RANGE_CLAMP),
      known_step(12'd250, 2'd1, 32'h0000_0000, 1'b0, asc_pkg::QUAL_STALE, asc_pkg::STAT_CLAMP),
      // clamp above, then crossed bounds settle on the high bound
      cfg_step(asc_pkg::REG_BIAS, 32'h7FFF_FFFF),
      known_step(12'd150, 2'd0, 32'h0064_0000, 1'b1, asc_pkg::QUAL_GOOD, asc_pkg::STAT_CLAMP),
      cfg_step(asc_pkg::REG_CLAMP_LOW, 32'h0064_0000),
      cfg_step(asc_pkg::REG_CLAMP_HIGH, 32'h000A_0000),
      cfg_step(asc_pkg::REG_BIAS, 32'd0),
      known_step(12'd150, 2'd0, 32'h000A_0000, 1'b1, asc_pkg::QUAL_GOOD, asc_pkg::STAT_CLAMP),
      // smoothing: seed, weight above one, zero weight, half weight rounding
      cfg_step(asc_pkg::REG_MODE, M_SCALE | M_EMA),
      cfg_step(asc_pkg::REG_GAIN, 32'h0001_0000),
      cfg_step(asc_pkg::REG_WEIGHT, 32'h0001_FFFF),
      sample_step(12'd150, 2'd0),
      sample_step(12'd160, 2'd0),
      cfg_step(asc_pkg::REG_WEIGHT, 32'd0),
      sample_step(12'd4095, 2'd2),
      cfg_step(asc_pkg::REG_WEIGHT, 32'h0000_8000),
      cfg_step(asc_pkg::REG_GAIN, 32'd1),
      sample_step(12'd161, 2'd0),
      sample_step(12'd0, 2'd1),
      // passthrough skips the range check and leaves the filter alone
      cfg_step(asc_pkg::REG_MODE, 32'd0),
      known_step(12'd7, 2'd0, 32'h0007_0000, 1'b1, asc_pkg::QUAL_GOOD, asc_pkg::STAT_OK),
      cfg_step(asc_pkg::REG_MODE, M_SCALE | M_EMA | M_CLAMP),
      sample_step(12'd155, 2'd0),
      sample_step(12'd4095, 2'd0)
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_WRITE: begin
          settle();
          write_reg(plan[i].idx, plan[i].wdata);
        end
        ROW_KNOWN: send_item(plan[i].raw, plan[i].link, 1'b1, plan[i].want);
        default:   send_item(plan[i].raw, plan[i].link, 1'b0, '0);
      endcase
    end

    // Random phases, each under a fresh register setting
    for (int p = 0; p < PHASES; p++) begin
      settle();
      randomize_setup();
      calm = (p >= CALM_FROM);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 8;
        default: stall_pct = 30;
      endcase
      lo_lim = (lim_a < lim_b) ? lim_a : lim_b;
      hi_lim = (lim_a < lim_b) ? lim_b : lim_a;
      for (int k = 0; k < PHASE_LEN; k++) begin
        case ($urandom_range(0, 9))
          0: raw = 12'd0;
          1: raw = 12'd4095;
          2: raw = lo_lim + 12'($urandom_range(0, 2)) - 12'd1;
          3: raw = hi_lim + 12'($urandom_range(0, 2)) - 12'd1;
          default: raw = $urandom_range(0, 4095);
        endcase
        // mostly good links, the rest spread over stale, fault and undefined
        r = $urandom_range(0, 7);
        link = (r < 4) ? 2'd0 : 2'(r - 4);
        send_item(raw, link, 1'b0, '0);
      end
    end

    settle();
    repeat (12) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
